// ===== rtl/egd_pkg.sv =====
// shared types, codes and helpers for the exp-golomb decoder
package egd_pkg;

  localparam int CHUNK_BITS = 8;
  localparam int RUN_W      = 5;
  localparam int LEFT_W     = 6;
  localparam int VAL_W      = 32;
  localparam int CNT_W      = 4;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_PREFIX = 2'd1,
    ERR_EOS    = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_END,
    ST_LAST
  } st_t;

  // one queued chunk, bit count already clamped to the chunk width
  typedef struct packed {
    logic [CHUNK_BITS-1:0] data;
    logic [CNT_W-1:0]      count;
    logic                  eos;
  } chunk_t;

  // one decoded code waiting to leave
  typedef struct packed {
    logic [VAL_W-1:0] uval;
    logic [VAL_W-1:0] sval;
    err_t             err;
  } res_t;

  // even v maps to -(v/2), odd v to (v+1)/2
  function automatic logic [VAL_W-1:0] signed_map(input logic [VAL_W-1:0] v);
    logic [VAL_W-1:0] h;
    h = v >> 1;
    return v[0] ? h + VAL_W'(1) : VAL_W'(0) - h;
  endfunction

endpackage

// ===== rtl/egd_if.sv =====
// stream channels: incoming bit chunks and decoded results
interface egd_chunk_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_bits;
  logic [3:0] bit_count;
  logic       end_of_stream;

  modport source (output valid, data_bits, bit_count, end_of_stream, input ready);
  modport sink   (input valid, data_bits, bit_count, end_of_stream, output ready);
endinterface

interface egd_result_if;
  logic               valid;
  logic               ready;
  logic [31:0]        unsigned_value;
  logic signed [31:0] signed_value;
  logic [1:0]         code_error;
  logic               last_of_chunk;

  modport source (output valid, unsigned_value, signed_value, code_error, last_of_chunk,
                  input ready);
  modport sink   (input valid, unsigned_value, signed_value, code_error, last_of_chunk,
                  output ready);
endinterface

// ===== rtl/egd_front.sv =====
// chunk intake: clamps the bit count and holds chunks in a two-entry queue
module egd_front (
  input  logic              clk,
  input  logic              rst,
  egd_chunk_if.sink         chunk,
  output logic              q_valid,
  output egd_pkg::chunk_t   q_item,
  input  logic              q_ready
);

  egd_pkg::chunk_t mem [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      fill;
  egd_pkg::chunk_t in_item;
  logic            push;
  logic            pop;

  always_comb begin
    in_item.data = chunk.data_bits;
    in_item.eos  = chunk.end_of_stream;
    if (chunk.bit_count > egd_pkg::CNT_W'(egd_pkg::CHUNK_BITS)) begin
      in_item.count = egd_pkg::CNT_W'(egd_pkg::CHUNK_BITS);
    end else begin
      in_item.count = chunk.bit_count;
    end
  end

  assign chunk.ready = (fill != 2'd2);
  assign push        = chunk.valid && chunk.ready;
  assign q_valid     = (fill != 2'd0);
  assign pop         = q_valid && q_ready;
  assign q_item      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== rtl/egd_back.sv =====
// bit-serial code engine: one stream bit per cycle unless the output stalls, results through an output register
module egd_back #(
  parameter int MAX_PREFIX = 31
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  egd_pkg::chunk_t   q_item,
  output logic              q_ready,
  egd_result_if.source      result
);

  egd_pkg::st_t st, st_next;

  // current chunk
  egd_pkg::chunk_t cur;
  logic [egd_pkg::CNT_W-1:0] idx;

  // decode state
  logic [egd_pkg::RUN_W-1:0]  zero_run;
  logic                       in_suffix;
  logic [egd_pkg::LEFT_W-1:0] suffix_left;
  logic [egd_pkg::VAL_W-1:0]  suffix_acc;

  // one result held back until we know whether it is the chunk's last
  logic          pend_valid;
  egd_pkg::res_t pend;

  // output register
  logic          out_valid;
  egd_pkg::res_t out_res;
  logic          out_last;

  // combinational step results
  logic                       cur_bit;
  logic                       bits_done;
  logic                       hit;
  egd_pkg::res_t              hit_res;
  logic [egd_pkg::RUN_W-1:0]  zero_run_next;
  logic                       in_suffix_next;
  logic [egd_pkg::LEFT_W-1:0] suffix_left_next;
  logic [egd_pkg::VAL_W-1:0]  suffix_acc_next;
  logic [egd_pkg::VAL_W-1:0]  acc_shift;
  logic [egd_pkg::LEFT_W-1:0] left_dec;
  logic                       flush_hit;
  logic                       out_free;
  logic                       fire;
  logic                       take_hit;
  logic                       move_pend;
  logic                       move_last;

  assign out_free  = !out_valid || result.ready;
  assign bits_done = (idx == cur.count);
  assign cur_bit   = cur.data[3'd7 - idx[2:0]];
  assign acc_shift = {suffix_acc[egd_pkg::VAL_W-2:0], cur_bit};
  assign left_dec  = suffix_left - egd_pkg::LEFT_W'(1);
  assign flush_hit = cur.eos && (in_suffix || (zero_run != '0));

  // single-bit decode step
  always_comb begin
    hit              = 1'b0;
    hit_res.uval     = '0;
    hit_res.err      = egd_pkg::ERR_NONE;
    zero_run_next    = zero_run;
    in_suffix_next   = in_suffix;
    suffix_left_next = suffix_left;
    suffix_acc_next  = suffix_acc;
    if (in_suffix) begin
      suffix_acc_next  = acc_shift;
      suffix_left_next = left_dec;
      if (left_dec == '0) begin
        hit              = 1'b1;
        hit_res.uval     = acc_shift - egd_pkg::VAL_W'(1);
        zero_run_next    = '0;
        in_suffix_next   = 1'b0;
        suffix_left_next = '0;
        suffix_acc_next  = '0;
      end
    end else if (!cur_bit) begin
      if (zero_run >= egd_pkg::RUN_W'(MAX_PREFIX)) begin
        hit              = 1'b1;
        hit_res.err      = egd_pkg::ERR_PREFIX;
        zero_run_next    = '0;
        suffix_left_next = '0;
        suffix_acc_next  = '0;
      end else begin
        zero_run_next = zero_run + egd_pkg::RUN_W'(1);
      end
    end else if (zero_run == '0) begin
      hit = 1'b1;
    end else begin
      in_suffix_next   = 1'b1;
      suffix_left_next = egd_pkg::LEFT_W'(zero_run);
      suffix_acc_next  = egd_pkg::VAL_W'(1);
      zero_run_next    = '0;
    end
    hit_res.sval = egd_pkg::signed_map(hit_res.uval);
  end

  // next state
  always_comb begin
    st_next = st;
    case (st)
      egd_pkg::ST_IDLE: if (q_valid) st_next = egd_pkg::ST_RUN;
      egd_pkg::ST_RUN:  if (bits_done) st_next = egd_pkg::ST_END;
      egd_pkg::ST_END:  if (fire) st_next = egd_pkg::ST_LAST;
      egd_pkg::ST_LAST: if (fire) st_next = egd_pkg::ST_IDLE;
      default:          st_next = egd_pkg::ST_IDLE;
    endcase
  end

  // step controls
  always_comb begin
    q_ready   = 1'b0;
    fire      = 1'b0;
    take_hit  = 1'b0;
    move_pend = 1'b0;
    move_last = 1'b0;
    case (st)
      egd_pkg::ST_IDLE: begin
        q_ready = 1'b1;
      end
      egd_pkg::ST_RUN: begin
        fire      = !bits_done && !(hit && pend_valid && !out_free);
        take_hit  = fire && hit;
        move_pend = take_hit && pend_valid;
      end
      egd_pkg::ST_END: begin
        fire      = !(flush_hit && pend_valid && !out_free);
        take_hit  = fire && flush_hit;
        move_pend = take_hit && pend_valid;
      end
      egd_pkg::ST_LAST: begin
        fire      = !pend_valid || out_free;
        move_last = pend_valid && out_free;
      end
      default: begin
        q_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= egd_pkg::ST_IDLE;
      idx         <= '0;
      zero_run    <= '0;
      in_suffix   <= 1'b0;
      suffix_left <= '0;
      suffix_acc  <= '0;
      pend_valid  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      st <= st_next;
      if (st == egd_pkg::ST_IDLE && q_valid) begin
        idx <= '0;
      end
      if (st == egd_pkg::ST_RUN && fire) begin
        idx         <= idx + egd_pkg::CNT_W'(1);
        zero_run    <= zero_run_next;
        in_suffix   <= in_suffix_next;
        suffix_left <= suffix_left_next;
        suffix_acc  <= suffix_acc_next;
      end
      if (st == egd_pkg::ST_END && fire && cur.eos) begin
        zero_run    <= '0;
        in_suffix   <= 1'b0;
        suffix_left <= '0;
        suffix_acc  <= '0;
      end
      if (take_hit) begin
        pend_valid <= 1'b1;
      end else if (move_last) begin
        pend_valid <= 1'b0;
      end
      if (move_pend || move_last) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (st == egd_pkg::ST_IDLE && q_valid) begin
      cur <= q_item;
    end
    if (take_hit) begin
      if (st == egd_pkg::ST_END) begin
        pend.uval <= '0;
        pend.sval <= '0;
        pend.err  <= egd_pkg::ERR_EOS;
      end else begin
        pend <= hit_res;
      end
    end
    if (move_pend || move_last) begin
      out_res  <= pend;
      out_last <= move_last;
    end
  end

  assign result.valid          = out_valid;
  assign result.unsigned_value = out_res.uval;
  assign result.signed_value   = signed'(out_res.sval);
  assign result.code_error     = out_res.err;
  assign result.last_of_chunk  = out_last;

  a_prefix_bound: assert property (@(posedge clk) disable iff (rst)
    zero_run <= egd_pkg::RUN_W'(MAX_PREFIX))
    else $error("zero run past prefix limit");

  a_suffix_shape: assert property (@(posedge clk) disable iff (rst)
    in_suffix |-> (suffix_left != '0) && (zero_run == '0))
    else $error("suffix state inconsistent");

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    (st == egd_pkg::ST_RUN) |-> (idx <= cur.count))
    else $error("bit index past chunk");

  a_last_marked: assert property (@(posedge clk) disable iff (rst)
    move_last |=> out_valid && out_last)
    else $error("closing result not marked last");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (st == egd_pkg::ST_IDLE) |-> !pend_valid)
    else $error("held result left behind");

endmodule

// ===== rtl/exp_golomb_decoder_top.sv =====
// Order-0 Exp-Golomb decoder. Chunks of up to eight stream bits (first bit in
// bit 7) enter a two-entry queue; the decode engine behind it consumes one
// stream bit per clock while the output does not stall, and takes one chunk at
// a time through load, one step per valid bit, end-of-bits check, stream-end
// check and final result release before it loads the next.
// Each finished code yields the ue value
// (codeword minus one) and its se mapping; a prefix longer than MAX_PREFIX
// zeros gives error 1 and restarts, a code cut off by end_of_stream gives
// error 2 with value 0. The last result of each chunk carries last_of_chunk,
// which is why one result is held inside the engine until the next one or
// the end of the chunk is known. A stalled output holds up only the engine;
// the queue keeps accepting chunks until it is full.
module exp_golomb_decoder_top #(
  parameter int MAX_PREFIX = 31
) (
  input  logic         clk,
  input  logic         rst,
  egd_chunk_if.sink    chunk,
  egd_result_if.source result
);

  logic            q_valid;
  logic            q_ready;
  egd_pkg::chunk_t q_item;

  egd_front u_front (
    .clk     (clk),
    .rst     (rst),
    .chunk   (chunk),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_ready (q_ready)
  );

  egd_back #(
    .MAX_PREFIX (MAX_PREFIX)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_ready (q_ready),
    .result  (result)
  );

endmodule

// ===== tb/sv/testbench.sv =====
// testbench for the exp-golomb decoder: directed and random bit chunks checked against a local decoder
`timescale 1ns / 100ps

module testbench;

  localparam int MAX_PREFIX  = 31;
  localparam int HOLD_CYCLES = 90;

  typedef struct packed {
    logic [31:0]   uval;
    logic [31:0]   sval;
    egd_pkg::err_t err;
    logic          last;
  } code_t;

  logic clk;
  logic rst;

  egd_chunk_if  chunk_bus ();
  egd_result_if result_bus ();

  exp_golomb_decoder_top #(.MAX_PREFIX(MAX_PREFIX)) DUT (
    .clk    (clk),
    .rst    (rst),
    .chunk  (chunk_bus),
    .result (result_bus)
  );

  // local copy of the decoder state
  logic [4:0]  zero_run;
  logic        in_suffix;
  logic [5:0]  suffix_left;
  logic [31:0] suffix_acc;

  code_t expected_codes[$];
  int    errors    = 0;
  bit    gaps_on   = 1'b1;
  bit    stalls_on = 1'b1;
  bit    hold_off  = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  function automatic void clear_decoder();
    zero_run    = '0;
    in_suffix   = 1'b0;
    suffix_left = '0;
    suffix_acc  = '0;
  endfunction

  function automatic code_t make_code(input logic [31:0] v, input egd_pkg::err_t err);
    code_t c;
    logic [32:0] up;
    up     = ({1'b0, v} + 33'd1) >> 1;
    c.uval = v;
    c.sval = v[0] ? up[31:0] : 32'd0 - (v >> 1);
    c.err  = err;
    c.last = 1'b0;
    return c;
  endfunction

  // walks the chunk bit by bit and queues the codes it completes
  function automatic void decode_chunk(input logic [7:0] d, input logic [3:0] n,
                                       input logic eos);
    code_t batch[$];
    code_t c;
    int    cnt;
    logic  b;
    cnt = (n > 4'd8) ? 8 : int'(n);
    for (int i = 0; i < cnt; i++) begin
      b = d[7 - i];
      if (in_suffix) begin
        suffix_acc  = {suffix_acc[30:0], b};
        suffix_left = suffix_left - 6'd1;
        if (suffix_left == 6'd0) begin
          batch.push_back(make_code(suffix_acc - 32'd1, egd_pkg::ERR_NONE));
          clear_decoder();
        end
      end else if (!b) begin
        if (zero_run >= MAX_PREFIX) begin
          batch.push_back(make_code(32'd0, egd_pkg::ERR_PREFIX));
          clear_decoder();
        end else begin
          zero_run = zero_run + 5'd1;
        end
      end else if (zero_run == 5'd0) begin
        batch.push_back(make_code(32'd0, egd_pkg::ERR_NONE));
      end else begin
        in_suffix   = 1'b1;
        suffix_left = {1'b0, zero_run};
        suffix_acc  = 32'd1;
        zero_run    = '0;
      end
    end
    if (eos) begin
      if (in_suffix || zero_run != 5'd0)
        batch.push_back(make_code(32'd0, egd_pkg::ERR_EOS));
      clear_decoder();
    end
    foreach (batch[k]) begin
      c      = batch[k];
      c.last = (k == batch.size() - 1);
      expected_codes.push_back(c);
    end
  endfunction

  task automatic send_chunk(input logic [7:0] d, input logic [3:0] n, input logic eos);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      chunk_bus.valid     <= 1'b0;
      chunk_bus.data_bits <= 8'($urandom);
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    chunk_bus.valid         <= 1'b1;
    chunk_bus.data_bits     <= d;
    chunk_bus.bit_count     <= n;
    chunk_bus.end_of_stream <= eos;
    do @(posedge clk); while (!chunk_bus.ready);
    decode_chunk(d, n, eos);
  endtask

  task automatic stop_sending();
    chunk_bus.valid <= 1'b0;
  endtask

  task automatic wait_all_decoded();
    @(posedge clk);
    while (expected_codes.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_chunk(8'hFF, 4'd8, 1'b0);          // eight one-bit codes
    send_chunk(8'b0100_1100, 4'd8, 1'b0);   // values 1 and 2, two zeros left over
    send_chunk(8'b1010_0000, 4'd3, 1'b0);   // finishes 00101
    send_chunk(8'hA5, 4'd0, 1'b0);          // empty chunk
    send_chunk(8'hFF, 4'd15, 1'b0);         // oversized count
    send_chunk(8'h80, 4'd9, 1'b0);          // one code then seven zeros
    send_chunk(8'hFF, 4'd8, 1'b0);          // seven-bit suffix
    send_chunk(8'h7F, 4'd1, 1'b0);          // bits past the count are ignored
    send_chunk(8'hFF, 4'd2, 1'b0);
    // longest prefix with an all-ones suffix
    repeat (3) send_chunk(8'h00, 4'd8, 1'b0);
    send_chunk(8'h01, 4'd8, 1'b0);
    repeat (3) send_chunk(8'hFF, 4'd8, 1'b0);
    send_chunk(8'hFE, 4'd7, 1'b0);
    // one zero too many
    repeat (4) send_chunk(8'h00, 4'd8, 1'b0);
    send_chunk(8'h00, 4'd3, 1'b1);          // stream ends inside the prefix
    send_chunk(8'hFF, 4'd2, 1'b1);          // stream ends between codes
    send_chunk(8'h40, 4'd2, 1'b0);
    send_chunk(8'h00, 4'd0, 1'b1);          // stream ends inside the suffix
  endtask

  // receiver holds off while chunks keep coming, so the input side fills up
  task automatic test_backpressure();
    gaps_on  = 1'b0;
    hold_off = 1'b1;
    repeat (14) send_chunk(8'hFF, 4'd8, 1'b0);
    while (hold_off) @(posedge clk);
    gaps_on = 1'b1;
  endtask

  task automatic test_drain_pause();
    send_chunk(8'b0010_0101, 4'd8, 1'b0);
    send_chunk(8'b1001_1000, 4'd6, 1'b0);
    stop_sending();
    wait_all_decoded();
    send_chunk(8'b0001_0010, 4'd8, 1'b0);
    send_chunk(8'b0110_0000, 4'd3, 1'b1);
    stop_sending();
    wait_all_decoded();
  endtask

  // mostly well-formed codes cut into random chunks, with some noise mixed in
  task automatic test_random_stream(input int n_items);
    bit         pend[$];
    int         sent;
    int         plen;
    int         cnt;
    logic [7:0] d;
    logic       eos;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        cnt = $urandom_range(0, 15);
        send_chunk(8'($urandom), 4'(cnt), $urandom_range(0, 7) == 0);
        if (cnt != 0)
          sent++;
      end else begin
        plen = ($urandom_range(0, 11) == 0) ? $urandom_range(7, 31) : $urandom_range(0, 6);
        repeat (plen) pend.push_back(1'b0);
        pend.push_back(1'b1);
        repeat (plen) pend.push_back(1'($urandom));
        while (pend.size() >= 8 || (pend.size() > 0 && $urandom_range(0, 2) == 0)) begin
          cnt = $urandom_range(1, 8);
          if (cnt > pend.size())
            cnt = pend.size();
          d = 8'($urandom);
          for (int i = 0; i < cnt; i++)
            d[7 - i] = pend.pop_front();
          // mostly at code boundaries, now and then in the middle of a code
          eos = ($urandom_range(0, 29) == 0) ||
                (pend.size() == 0 && $urandom_range(0, 9) == 0);
          send_chunk(d, 4'(cnt), eos);
          sent++;
        end
      end
    end
  endtask

  initial begin : result_sink
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        result_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
      end else if (stalls_on && $urandom_range(0, 4) == 0) begin
        result_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        result_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    code_t want;
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (expected_codes.size() == 0) begin
        $error("item with nothing expected: unsigned_value=%0d code_error=%0d",
               result_bus.unsigned_value, result_bus.code_error);
        errors++;
      end else begin
        want = expected_codes.pop_front();
        if (result_bus.unsigned_value !== want.uval) begin
          $error("unsigned_value: expected %0d, got %0d", want.uval,
                 result_bus.unsigned_value);
          errors++;
        end
        if (result_bus.signed_value !== want.sval) begin
          $error("signed_value: expected %0d, got %0d", $signed(want.sval),
                 result_bus.signed_value);
          errors++;
        end
        if (result_bus.code_error !== want.err) begin
          $error("code_error: expected %0d, got %0d", want.err, result_bus.code_error);
          errors++;
        end
        if (result_bus.last_of_chunk !== want.last) begin
          $error("last_of_chunk: expected %0d, got %0d", want.last,
                 result_bus.last_of_chunk);
          errors++;
        end
      end
    end
  end

  initial begin
    clear_decoder();
    rst                     <= 1'b1;
    chunk_bus.valid         <= 1'b0;
    chunk_bus.data_bits     <= '0;
    chunk_bus.bit_count     <= '0;
    chunk_bus.end_of_stream <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_backpressure();
    test_drain_pause();
    test_random_stream(160);
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    test_random_stream(30);
    stop_sending();

    wait_all_decoded();
    repeat (40) @(posedge clk);
    if (errors == 0 && expected_codes.size() == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule
